>>> hdl/tdr_pkg.sv
// Shared types and constants of the task dependency resolver.
package tdr_pkg;
    localparam int NUM_TASKS = 1024;
    localparam int NUM_EDGES = 4096;
    localparam int MAX_SUCC  = 32;
    localparam int TID_W     = $clog2(NUM_TASKS);
    localparam int EIDX_W    = $clog2(NUM_EDGES);
    localparam int LEN_W     = 6;
    localparam int PRED_W    = 8;
    localparam int CNT_W     = 11;
    localparam int ADDR_W    = 3;

    localparam logic [1:0] MODE_TASK = 2'd0;
    localparam logic [1:0] MODE_EDGE = 2'd1;
    localparam logic [1:0] MODE_DONE = 2'd2;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_READY = 2'd1;
    localparam logic [1:0] KIND_NEAR  = 2'd2;

    localparam logic [ADDR_W-1:0] REG_TOTAL_TASKS = '0;

    typedef struct packed {
        logic [PRED_W-1:0] pred;
        logic [TID_W-1:0]  xacc;
        logic              queued;
        logic              tkind;
        logic [EIDX_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } t_task_row;

    typedef struct packed {
        logic [1:0]       kind;
        logic [TID_W-1:0] task_id;
        logic             tkind;
        logic [TID_W-1:0] wpred;
    } t_result;
endpackage

>>> hdl/tdr_cfg_regs.sv
// Configuration register file with the bus port.
module tdr_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tdr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [tdr_pkg::CNT_W-1:0] o_total
);
    import tdr_pkg::*;
    logic [CNT_W-1:0] r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (psel && penable && pwrite && paddr == REG_TOTAL_TASKS) begin
            r_total <= pwdata[CNT_W-1:0];
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr == REG_TOTAL_TASKS) ? {{(32-CNT_W){1'b0}}, r_total} : 32'd0;
    assign o_total = r_total;
endmodule

>>> hdl/tdr_task_mem.sv
// Task record memory with one write port and one registered read port.
module tdr_task_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [tdr_pkg::TID_W-1:0] i_waddr,
    input  tdr_pkg::t_task_row        i_wdata,
    input  logic [tdr_pkg::TID_W-1:0] i_raddr,
    output tdr_pkg::t_task_row        o_rdata
);
    import tdr_pkg::*;
    t_task_row r_mem [NUM_TASKS];
    t_task_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/tdr_edge_mem.sv
// Successor table memory with one write port and one registered read port.
module tdr_edge_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [tdr_pkg::EIDX_W-1:0] i_waddr,
    input  logic [tdr_pkg::TID_W-1:0]  i_wdata,
    input  logic [tdr_pkg::EIDX_W-1:0] i_raddr,
    output logic [tdr_pkg::TID_W-1:0]  o_rdata
);
    import tdr_pkg::*;
    logic [TID_W-1:0] r_mem [NUM_EDGES];
    logic [TID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/task_dependency_resolver_core.sv
// Top level of the task dependency resolver: sequencer, walk logic and result stage.
//
//  channel   direction  signals                     content
//  s_axis    in         tvalid tready tdata tuser   load or completion request
//  m_axis    out        tvalid tready tdata tuser   result, tlast on the final one
//  apb       in         psel penable pwrite paddr   total_tasks register
//
// A task load, edge load or unused mode passes S_FIN only. A completion walks
// S_INFO, then S_EWAIT (edge read) and S_TWAIT (task row read-modify-write)
// per successor, then S_FIN. After reset a clearing pass zeroes all 1024 task
// memory rows; no request is taken meanwhile. Output stalls hold the walk at
// the next report.
module task_dependency_resolver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: task_id, pred_count, succ_start, succ_count, task_kind,
    // edge_index, edge_target, zero fill
    input  logic [63:0] s_axis_tdata,
    // tuser: mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_task, out_kind, waiting_pred, all_done, zero fill
    output logic [23:0] m_axis_tdata,
    // tuser: kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [tdr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tdr_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_INFO  = 7'b0000100,
        S_EWAIT = 7'b0001000,
        S_TWAIT = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [TID_W-1:0]   r_clr;
    logic [TID_W-1:0]   r_tid;
    logic [TID_W-1:0]   r_sid;
    logic [EIDX_W-1:0]  r_base;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_done_cnt;
    logic               r_done_flag;
    logic               r_hold_v;
    t_result            r_hold;
    logic               r_ov;
    t_result            r_out;
    logic               r_olast;
    logic               r_odone;

    logic [CNT_W-1:0]   total;
    logic               t_we;
    logic [TID_W-1:0]   t_waddr;
    t_task_row          t_wdata;
    logic [TID_W-1:0]   t_raddr;
    t_task_row          t_rdata;
    logic               e_we;
    logic [EIDX_W-1:0]  e_raddr;
    logic [TID_W-1:0]   e_rdata;

    logic [1:0]         in_mode;
    logic [TID_W-1:0]   in_tid;
    logic [PRED_W-1:0]  in_pred;
    logic [EIDX_W-1:0]  in_start;
    logic [LEN_W-1:0]   in_cnt;
    logic               in_kind;
    logic [EIDX_W-1:0]  in_eidx;
    logic [TID_W-1:0]   in_etgt;
    logic               accept;
    logic               out_free;
    logic               out_load;
    logic [LEN_W-1:0]   info_len;
    logic [LEN_W-1:0]   n_k;
    logic [PRED_W-1:0]  n_pred;
    logic [TID_W-1:0]   n_xacc;
    logic               mod_emit;
    logic               mod_go;
    t_result            mod_res;
    logic [CNT_W-1:0]   n_done_cnt;

    assign in_mode  = s_axis_tuser;
    assign in_tid   = s_axis_tdata[9:0];
    assign in_pred  = s_axis_tdata[17:10];
    assign in_start = s_axis_tdata[29:18];
    assign in_cnt   = s_axis_tdata[35:30];
    assign in_kind  = s_axis_tdata[36];
    assign in_eidx  = s_axis_tdata[48:37];
    assign in_etgt  = s_axis_tdata[58:49];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;

    assign info_len = (t_rdata.len > LEN_W'(MAX_SUCC)) ? LEN_W'(MAX_SUCC) : t_rdata.len;
    assign n_k      = r_k + LEN_W'(1);
    assign n_pred   = (t_rdata.pred != '0) ? t_rdata.pred - PRED_W'(1) : '0;
    assign n_xacc   = t_rdata.xacc ^ r_tid;
    assign mod_emit = !t_rdata.queued && (n_pred <= PRED_W'(1));
    assign mod_go   = !mod_emit || !r_hold_v || out_free;
    assign n_done_cnt = (r_done_cnt != {CNT_W{1'b1}}) ? r_done_cnt + CNT_W'(1) : r_done_cnt;
    assign out_load = (r_state == S_TWAIT && mod_go && mod_emit && r_hold_v) ||
                      (r_state == S_FIN && out_free);

    always_comb begin
        mod_res.kind    = (n_pred == '0) ? KIND_READY : KIND_NEAR;
        mod_res.task_id = r_sid;
        mod_res.tkind   = t_rdata.tkind;
        mod_res.wpred   = n_xacc;
    end

    always_comb begin
        t_we    = 1'b0;
        t_waddr = r_sid;
        t_wdata = t_rdata;
        e_we    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                t_we    = 1'b1;
                t_waddr = r_clr;
                t_wdata = '0;
            end
            S_IDLE: begin
                t_we           = accept && (in_mode == MODE_TASK);
                t_waddr        = in_tid;
                t_wdata.pred   = in_pred;
                t_wdata.xacc   = '0;
                t_wdata.queued = (in_pred <= PRED_W'(1));
                t_wdata.tkind  = in_kind;
                t_wdata.base   = in_start;
                t_wdata.len    = in_cnt;
                e_we           = accept && (in_mode == MODE_EDGE);
            end
            S_TWAIT: begin
                t_we           = !t_rdata.queued && mod_go;
                t_wdata.pred   = n_pred;
                t_wdata.xacc   = n_xacc;
                t_wdata.queued = (n_pred == PRED_W'(1));
            end
            default: begin
                t_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:  t_raddr = in_tid;
            S_EWAIT: t_raddr = e_rdata;
            default: t_raddr = r_sid;
        endcase
        e_raddr = (r_state == S_INFO) ? t_rdata.base : r_base + EIDX_W'(n_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_done_cnt  <= '0;
            r_done_flag <= 1'b0;
            r_hold_v    <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + TID_W'(1);
                    if (r_clr == {TID_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_tid <= in_tid;
                        r_sid <= in_tid;
                        r_state <= (in_mode == MODE_DONE) ? S_INFO : S_FIN;
                        if (in_mode == MODE_TASK && in_pred <= PRED_W'(1)) begin
                            r_hold_v       <= 1'b1;
                            r_hold.kind    <= (in_pred == '0) ? KIND_READY : KIND_NEAR;
                            r_hold.task_id <= in_tid;
                            r_hold.tkind   <= in_kind;
                            r_hold.wpred   <= '0;
                        end
                        if (in_mode == MODE_DONE) begin
                            r_done_cnt <= n_done_cnt;
                            if (n_done_cnt >= total) begin
                                r_done_flag <= 1'b1;
                            end
                        end
                    end
                end
                S_INFO: begin
                    r_base <= t_rdata.base;
                    r_len  <= info_len;
                    r_k    <= '0;
                    r_state <= (info_len == '0) ? S_FIN : S_EWAIT;
                end
                S_EWAIT: begin
                    r_sid   <= e_rdata;
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (mod_go) begin
                        if (mod_emit) begin
                            r_hold_v <= 1'b1;
                            r_hold   <= mod_res;
                            if (r_hold_v) begin
                                r_out   <= r_hold;
                                r_olast <= 1'b0;
                                r_odone <= r_done_flag;
                            end
                        end
                        r_k     <= n_k;
                        r_state <= (n_k == r_len) ? S_FIN : S_EWAIT;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out    <= r_hold_v ? r_hold : t_result'('0);
                        r_olast  <= 1'b1;
                        r_odone  <= r_done_flag;
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {2'b00, r_odone, r_out.wpred, r_out.tkind, r_out.task_id};

    tdr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_total (total)
    );

    tdr_task_mem u_task_mem (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    tdr_edge_mem u_edge_mem (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (in_eidx),
        .i_wdata (in_etgt),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );
endmodule
